// ===== sv/exq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exq_pkg: shared constants and types for the Euler XYZ to quaternion core
// Widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package exq_pkg;
  localparam int ANGLE_BITS = 18;
  localparam int QUAT_BITS  = 18;
  localparam int NUM_ITER   = 30;
  localparam int NUM_LANES  = 3;
  localparam int CW         = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sh0C90FDAA2;
  localparam logic signed [CW-1:0] PI_HALF_Q30 = 34'sh06487ED51;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [QUAT_BITS-1:0]  quat_t;
  typedef logic signed [CW-1:0]         cw_t;

  typedef struct packed {
    cw_t s;
    cw_t c;
  } sincos_t;

  function automatic cw_t atan_lut(input logic [4:0] i);
    cw_t r;
    r = '0;
    unique case (i)
      5'd0:  r = 34'sh3243F6A8;  5'd1:  r = 34'sh1DAC6705;
      5'd2:  r = 34'sh0FADBAFC;  5'd3:  r = 34'sh07F56EA6;
      5'd4:  r = 34'sh03FEAB76;  5'd5:  r = 34'sh01FFD55B;
      5'd6:  r = 34'sh00FFFAAA;  5'd7:  r = 34'sh007FFF55;
      5'd8:  r = 34'sh003FFFEA;  5'd9:  r = 34'sh001FFFFD;
      5'd10: r = 34'sh000FFFFF;  5'd11: r = 34'sh0007FFFF;
      5'd12: r = 34'sh0003FFFF;  5'd13: r = 34'sh0001FFFF;
      5'd14: r = 34'sh0000FFFF;  5'd15: r = 34'sh00007FFF;
      5'd16: r = 34'sh00003FFF;  5'd17: r = 34'sh00001FFF;
      5'd18: r = 34'sh00000FFF;  5'd19: r = 34'sh000007FF;
      5'd20: r = 34'sh000003FF;  5'd21: r = 34'sh000001FF;
      5'd22: r = 34'sh000000FF;  5'd23: r = 34'sh0000007F;
      5'd24: r = 34'sh0000003F;  5'd25: r = 34'sh0000001F;
      5'd26: r = 34'sh0000000F;  5'd27: r = 34'sh00000008;
      5'd28: r = 34'sh00000004;  5'd29: r = 34'sh00000002;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== sv/exq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exq_angle_if / exq_quat_if: valid-ready channels
// Input channel carries three angles, output channel four quaternion terms.
// ----------------------------------------------------------------------------
interface exq_angle_if;
  import exq_pkg::*;
  logic   valid;
  logic   ready;
  angle_t angle_x;
  angle_t angle_y;
  angle_t angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface exq_quat_if;
  import exq_pkg::*;
  logic  valid;
  logic  ready;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  quat_t quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== sv/exq_cordic_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exq_cordic_lane: pipelined half-angle sine/cosine
// Fold, then one CORDIC micro-rotation per stage; advances when en_i is high.
// ----------------------------------------------------------------------------
module exq_cordic_lane
  import exq_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  angle_t  angle_i,
  output sincos_t sc_o
);
  cw_t  x_q [NUM_ITER+1];
  cw_t  y_q [NUM_ITER+1];
  cw_t  z_q [NUM_ITER+1];
  logic n_q [NUM_ITER+1];
  cw_t  h;

  assign h = cw_t'(angle_i) <<< (32 - ANGLE_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_GAIN;
      y_q[0] <= '0;
      if (h > PI_HALF_Q30) begin
        z_q[0] <= h - PI_Q30;
        n_q[0] <= 1'b1;
      end else if (h < -PI_HALF_Q30) begin
        z_q[0] <= h + PI_Q30;
        n_q[0] <= 1'b1;
      end else begin
        z_q[0] <= h;
        n_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= n_q[i];
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_lut(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_lut(5'(i));
        end
      end
    end
  end

  assign sc_o.c = n_q[NUM_ITER] ? -x_q[NUM_ITER] : x_q[NUM_ITER];
  assign sc_o.s = n_q[NUM_ITER] ? -y_q[NUM_ITER] : y_q[NUM_ITER];
endmodule

// ===== sv/exq_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exq_merge: combine lane results into the quaternion
// Stage 1 pair products, stage 2 triple products, stage 3 sum/round/clamp.
// ----------------------------------------------------------------------------
module exq_merge
  import exq_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  sincos_t scx_i,
  input  sincos_t scy_i,
  input  sincos_t scz_i,
  output quat_t   qx_o,
  output quat_t   qy_o,
  output quat_t   qz_o,
  output quat_t   qw_o
);
  localparam int PW = 2 * CW;
  localparam int SH = 62 - QUAT_BITS;
  typedef logic signed [PW-1:0] pw_t;

  sincos_t sx_q;
  cw_t  cycz_q, sysz_q, cysz_q, sycz_q;
  pw_t  t_q [8];
  quat_t qx_q, qy_q, qz_q, qw_q;

  function automatic cw_t rnd30(input pw_t p);
    pw_t r;
    r = (p + (pw_t'(1) <<< 29)) >>> 30;
    return r[CW-1:0];
  endfunction

  function automatic quat_t fin(input pw_t v);
    pw_t r;
    pw_t one;
    r   = (v + (pw_t'(1) <<< (SH - 1))) >>> SH;
    one = pw_t'(1) <<< (QUAT_BITS - 2);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[QUAT_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q   <= scx_i;
      cycz_q <= rnd30(scy_i.c * scz_i.c);
      sysz_q <= rnd30(scy_i.s * scz_i.s);
      cysz_q <= rnd30(scy_i.c * scz_i.s);
      sycz_q <= rnd30(scy_i.s * scz_i.c);
      t_q[0] <= sx_q.s * cycz_q;
      t_q[1] <= sx_q.c * sysz_q;
      t_q[2] <= sx_q.c * sycz_q;
      t_q[3] <= sx_q.s * cysz_q;
      t_q[4] <= sx_q.s * sycz_q;
      t_q[5] <= sx_q.c * cysz_q;
      t_q[6] <= sx_q.c * cycz_q;
      t_q[7] <= sx_q.s * sysz_q;
      qx_q <= fin(t_q[0] + t_q[1]);
      qy_q <= fin(t_q[2] - t_q[3]);
      qz_q <= fin(t_q[4] + t_q[5]);
      qw_q <= fin(t_q[6] - t_q[7]);
    end
  end

  assign qx_o = qx_q;
  assign qy_o = qy_q;
  assign qz_o = qz_q;
  assign qw_o = qw_q;
endmodule

// ===== sv/euler_xyz_to_quaternion_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_to_quaternion_core: Euler XYZ angles to unit quaternion
// Throughput: one transaction per cycle unless stalled; three CORDIC lanes of
//   31 stages each plus a 3-stage product/sum merge, all advancing together.
// Backpressure stalls the whole pipeline while the output holds a result.
// Reset clears the valid pipeline only; no data state is kept.
// ----------------------------------------------------------------------------
module euler_xyz_to_quaternion_core
  import exq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  exq_angle_if.sink   in_i,
  exq_quat_if.source  out_o
);
  localparam int DEPTH = NUM_ITER + 1 + 3;

  logic [DEPTH-1:0] vld_q;
  logic             en;
  sincos_t          sc [NUM_LANES];
  angle_t           ang [NUM_LANES];

  assign en       = !vld_q[DEPTH-1] || out_o.ready;
  assign in_i.ready = en;
  assign ang[0] = in_i.angle_x;
  assign ang[1] = in_i.angle_y;
  assign ang[2] = in_i.angle_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_i.valid};
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    exq_cordic_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (ang[l]),
      .sc_o    (sc[l])
    );
  end

  exq_merge u_merge (
    .clk_i (clk_i),
    .en_i  (en),
    .scx_i (sc[0]),
    .scy_i (sc[1]),
    .scz_i (sc[2]),
    .qx_o  (out_o.quat_x),
    .qy_o  (out_o.quat_y),
    .qz_o  (out_o.quat_z),
    .qw_o  (out_o.quat_w)
  );

  assign out_o.valid = vld_q[DEPTH-1];
endmodule

// ===== sv/exq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exq_checker: port-level checks for the quaternion core
// Range of quat_x and quat_w results and stall behavior of the output.
// ----------------------------------------------------------------------------
module exq_checker
  import exq_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input quat_t quat_x_i,
  input quat_t quat_w_i
);
  localparam quat_t ONE = quat_t'(1) <<< (QUAT_BITS - 2);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(quat_x_i))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input blocked without output stall");
  a_range_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> quat_x_i <= ONE && quat_x_i >= -ONE)
    else $error("quat_x out of range");
  a_range_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> quat_w_i <= ONE && quat_w_i >= -ONE)
    else $error("quat_w out of range");
endmodule

bind euler_xyz_to_quaternion_core exq_checker u_exq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .quat_x_i    (out_o.quat_x),
  .quat_w_i    (out_o.quat_w)
);
